[rtl/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Shared widths, request kinds and record types of the timer table.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int ID_W       = 6;
  localparam int TIME_W     = 32;
  localparam int REQ_W      = 3;
  localparam int MAX_TIMERS = 64;

  // request kinds as they arrive on tuser
  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd5;

  // operations as classified by the front end
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;
  localparam logic [2:0] OP_NOP    = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   id;
    logic              in_range;
    logic              periodic;
    logic [TIME_W-1:0] duration_ms;
    logic [TIME_W-1:0] now_ms;
  } tte_req_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            status;
    logic            expired;
    logic            last;
  } tte_res_t;

  function automatic tte_res_t mk_res(logic [ID_W-1:0] id, logic status,
                                      logic expired, logic last);
    tte_res_t r;
    r.id      = id;
    r.status  = status;
    r.expired = expired;
    r.last    = last;
    return r;
  endfunction

endpackage

[rtl/timer_table_expiry.sv]
// ----------------------------------------------------------------------------
// timer_table_expiry
// Pool of one-shot and periodic millisecond timers with a sorted expiry scan.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed one at a time. Create,
// stop, delete and unused codes finish in the idle state; start and query pass
// through a further state, set by the registered read of the period and expiry
// memories. An expiry check scans the expiry memory once per expired timer
// plus a final pass, one entry per cycle through its single read port, and
// passes through a reload state for each periodic timer that expires.
// Results sit in an output register, so a stalled result only holds the back
// end while new requests still fill the queue.
module timer_table_expiry #(
  parameter int NUM_TIMERS = tte_pkg::MAX_TIMERS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // timer_id[5:0], periodic[6], duration_ms[38:7], now_ms[70:39], zero[71]
  input  logic [71:0]               s_axis_tdata,
  // req_type[2:0]
  input  logic [tte_pkg::REQ_W-1:0] s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // result_id[5:0], status[6], expired[7]
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast
);
  import tte_pkg::*;

  logic     q_valid;
  logic     q_pop;
  tte_req_t q_req;

  tte_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_req         (q_req)
  );

  tte_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_req         (q_req),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[rtl/tte_front.sv]
// ----------------------------------------------------------------------------
// tte_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tte_front #(
  parameter int NUM_TIMERS = tte_pkg::MAX_TIMERS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [71:0]              s_axis_tdata,
  input  logic [tte_pkg::REQ_W-1:0] s_axis_tuser,
  output logic                     q_valid,
  input  logic                     q_pop,
  output tte_pkg::tte_req_t        q_req
);
  import tte_pkg::*;

  tte_req_t   fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  tte_req_t   cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.id          = s_axis_tdata[5:0];
    cls.periodic    = s_axis_tdata[6];
    cls.duration_ms = s_axis_tdata[38:7];
    cls.now_ms      = s_axis_tdata[70:39];
    cls.in_range    = ({1'b0, s_axis_tdata[5:0]} < (ID_W+1)'(NUM_TIMERS));
    case (s_axis_tuser)
      REQ_CREATE: cls.op = OP_CREATE;
      REQ_START:  cls.op = OP_START;
      REQ_STOP:   cls.op = OP_STOP;
      REQ_DELETE: cls.op = OP_DELETE;
      REQ_CHECK:  cls.op = OP_CHECK;
      REQ_QUERY:  cls.op = OP_QUERY;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (cnt != 2'd0);
  assign pop           = q_pop && q_valid;
  assign q_req         = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

[rtl/tte_back.sv]
// ----------------------------------------------------------------------------
// tte_back
// Carries out queued requests on the timer table and drives the result stage.
// ----------------------------------------------------------------------------
module tte_back #(
  parameter int NUM_TIMERS = tte_pkg::MAX_TIMERS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  tte_pkg::tte_req_t q_req,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // result_id[5:0], status[6], expired[7]
  output logic              m_axis_tlast
);
  import tte_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_QUERY  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RELOAD = 3'd4;

  logic [2:0] state;

  logic [NUM_TIMERS-1:0] in_use;
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] is_per;
  logic [NUM_TIMERS-1:0] picked;

  logic [TIME_W-1:0] per_mem [NUM_TIMERS];
  logic [TIME_W-1:0] exp_mem [NUM_TIMERS];
  logic [TIME_W-1:0] per_q;
  logic [TIME_W-1:0] exp_q;

  logic              per_we;
  logic [IDX_W-1:0]  per_waddr;
  logic [IDX_W-1:0]  per_raddr;
  logic              exp_we;
  logic [IDX_W-1:0]  exp_waddr;
  logic [TIME_W-1:0] exp_wdata;
  logic [IDX_W-1:0]  exp_raddr;

  logic [IDX_W-1:0]  cur_idx;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  scan_cnt;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic              best_v;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_exp;
  logic              have_pend;
  logic [IDX_W-1:0]  pend_idx;

  logic              out_valid;
  tte_res_t          out_q;

  logic [IDX_W-1:0]  req_idx;
  logic              req_ok;
  logic              out_free;
  logic              scanning;
  logic              pass_end;
  logic              cand;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  assign req_idx  = q_req.id[IDX_W-1:0];
  assign req_ok   = q_req.in_range && in_use[req_idx];
  assign out_free = !out_valid || m_axis_tready;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;
  assign scanning = (state == ST_SCAN) && (scan_cnt < CNT_W'(NUM_TIMERS));
  assign pass_end = (state == ST_SCAN) && (scan_cnt == CNT_W'(NUM_TIMERS))
                    && !cmp_valid && out_free;
  assign cand     = in_use[cmp_idx] && running[cmp_idx] && !picked[cmp_idx]
                    && (exp_q < now_q);

  // lowest free id
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    per_we    = 1'b0;
    per_waddr = free_idx;
    per_raddr = req_idx;
    exp_we    = 1'b0;
    exp_waddr = free_idx;
    exp_wdata = '0;
    exp_raddr = req_idx;
    case (state)
      ST_IDLE: begin
        if (q_pop && q_req.op == OP_CREATE && free_found) begin
          per_we = 1'b1;
          exp_we = 1'b1;
        end
      end
      ST_START: begin
        exp_we    = 1'b1;
        exp_waddr = cur_idx;
        exp_wdata = now_q + per_q;
      end
      ST_SCAN: begin
        exp_raddr = scan_cnt[IDX_W-1:0];
        per_raddr = best_idx;
      end
      ST_RELOAD: begin
        exp_we    = 1'b1;
        exp_waddr = pend_idx;
        exp_wdata = now_q + per_q;
      end
      default: begin
        exp_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[per_waddr] <= q_req.duration_ms;
    end
    per_q <= per_mem[per_raddr];
  end

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[exp_waddr] <= exp_wdata;
    end
    exp_q <= exp_mem[exp_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_use    <= '0;
      running   <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
      best_v    <= 1'b0;
      have_pend <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      cmp_valid <= scanning;
      cmp_idx   <= scan_cnt[IDX_W-1:0];
      if (scanning) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      // keep the earliest candidate; ascending scan leaves ties to the lower id
      if (cmp_valid && cand && (!best_v || exp_q < best_exp)) begin
        best_v   <= 1'b1;
        best_idx <= cmp_idx;
        best_exp <= exp_q;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur_idx <= req_idx;
            now_q   <= q_req.now_ms;
            case (q_req.op)
              OP_CREATE: begin
                out_valid <= 1'b1;
                if (free_found) begin
                  in_use[free_idx]  <= 1'b1;
                  running[free_idx] <= 1'b0;
                  is_per[free_idx]  <= q_req.periodic;
                  out_q <= mk_res(ID_W'(free_idx), 1'b0, 1'b0, 1'b1);
                end else begin
                  out_q <= mk_res('0, 1'b1, 1'b0, 1'b1);
                end
              end
              OP_START: begin
                out_valid <= 1'b1;
                out_q     <= mk_res(q_req.id, 1'b0, 1'b0, 1'b1);
                if (req_ok) begin
                  state <= ST_START;
                end
              end
              OP_STOP: begin
                out_valid <= 1'b1;
                out_q     <= mk_res(q_req.id, 1'b0, 1'b0, 1'b1);
                if (req_ok) begin
                  running[req_idx] <= 1'b0;
                end
              end
              OP_DELETE: begin
                out_valid <= 1'b1;
                out_q     <= mk_res(q_req.id, 1'b0, 1'b0, 1'b1);
                if (req_ok) begin
                  in_use[req_idx]  <= 1'b0;
                  running[req_idx] <= 1'b0;
                end
              end
              OP_CHECK: begin
                picked    <= '0;
                have_pend <= 1'b0;
                best_v    <= 1'b0;
                scan_cnt  <= '0;
                state     <= ST_SCAN;
              end
              OP_QUERY: begin
                if (req_ok) begin
                  state <= ST_QUERY;
                end else begin
                  out_valid <= 1'b1;
                  out_q     <= mk_res(q_req.id, 1'b0, 1'b0, 1'b1);
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_q     <= mk_res(q_req.id, 1'b0, 1'b0, 1'b1);
              end
            endcase
          end
        end
        ST_START: begin
          running[cur_idx] <= 1'b1;
          state            <= ST_IDLE;
        end
        ST_QUERY: begin
          out_valid <= 1'b1;
          out_q     <= mk_res(ID_W'(cur_idx), 1'b0, exp_q < now_q, 1'b1);
          state     <= ST_IDLE;
        end
        ST_SCAN: begin
          if (pass_end) begin
            if (best_v) begin
              // release the previous pick now that another one follows
              if (have_pend) begin
                out_valid <= 1'b1;
                out_q     <= mk_res(ID_W'(pend_idx), 1'b0, 1'b1, 1'b0);
              end
              picked[best_idx] <= 1'b1;
              pend_idx         <= best_idx;
              have_pend        <= 1'b1;
              best_v           <= 1'b0;
              scan_cnt         <= '0;
              if (is_per[best_idx]) begin
                state <= ST_RELOAD;
              end else begin
                running[best_idx] <= 1'b0;
              end
            end else begin
              out_valid <= 1'b1;
              out_q     <= mk_res(have_pend ? ID_W'(pend_idx) : '0, 1'b0, have_pend, 1'b1);
              state     <= ST_IDLE;
            end
          end
        end
        ST_RELOAD: begin
          state <= ST_SCAN;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_q.expired, out_q.status, out_q.id};
  assign m_axis_tlast  = out_q.last;

endmodule

[tb/sv/timer_table_checker.sv]
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches both streams of the timer table, predicts the results of every
// accepted request from its own copy of the timer state and compares them.
// ----------------------------------------------------------------------------
module timer_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  localparam int NT = MAX_TIMERS;

  bit          used [NT];
  bit          run [NT];
  bit          per [NT];
  logic [31:0] period [NT];
  logic [31:0] expiry [NT];

  tte_res_t results_due[$];

  assign pending = results_due.size();

  task automatic report(string what, tte_res_t got, tte_res_t want);
    $display("mismatch %s: got id=%0d st=%0b ex=%0b last=%0b, %s",
             what, got.id, got.status, got.expired, got.last,
             $sformatf("want id=%0d st=%0b ex=%0b last=%0b",
                       want.id, want.status, want.expired, want.last));
    errors++;
  endtask

  task automatic predict_request(logic [2:0] kind, logic [71:0] d);
    logic [5:0]  id;
    logic        p;
    logic [31:0] dur;
    logic [31:0] now;
    bit          picked [NT];
    int          order[$];
    int          best;
    bit          done;
    id  = d[5:0];
    p   = d[6];
    dur = d[38:7];
    now = d[70:39];
    case (kind)
      REQ_CREATE: begin
        done = 0;
        for (int i = 0; i < NT && !done; i++) begin
          if (!used[i]) begin
            used[i] = 1; run[i] = 0; per[i] = p; period[i] = dur; expiry[i] = 0;
            results_due.push_back(mk_res(i[5:0], 1'b0, 1'b0, 1'b1));
            done = 1;
          end
        end
        if (!done) results_due.push_back(mk_res(6'd0, 1'b1, 1'b0, 1'b1));
      end
      REQ_CHECK: begin
        foreach (picked[i]) picked[i] = 0;
        forever begin
          best = -1;
          for (int i = 0; i < NT; i++)
            if (used[i] && run[i] && !picked[i] && expiry[i] < now)
              if (best < 0 || expiry[i] < expiry[best]) best = i;
          if (best < 0) break;
          picked[best] = 1;
          order.push_back(best);
        end
        if (order.size() == 0) results_due.push_back(mk_res(6'd0, 1'b0, 1'b0, 1'b1));
        foreach (order[k]) begin
          if (per[order[k]]) expiry[order[k]] = now + period[order[k]];
          else run[order[k]] = 0;
          results_due.push_back(mk_res(order[k][5:0], 1'b0, 1'b1,
                                       k == order.size() - 1));
        end
      end
      REQ_QUERY:
        results_due.push_back(mk_res(id, 1'b0, used[id] && expiry[id] < now, 1'b1));
      default: begin
        if (used[id]) begin
          if (kind == REQ_START) begin
            expiry[id] = now + period[id];
            run[id] = 1;
          end else if (kind == REQ_STOP) begin
            run[id] = 0;
          end else if (kind == REQ_DELETE) begin
            used[id] = 0;
            run[id] = 0;
          end
        end
        results_due.push_back(mk_res(id, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    tte_res_t got;
    tte_res_t want;
    if (rst) begin
      foreach (used[i]) begin
        used[i] = 0;
        run[i] = 0;
      end
      results_due.delete();
      errors = 0;
    end else begin
      // compare first: a result never stems from a request taken in the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_res(m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[7], m_axis_tlast);
        if (results_due.size() == 0) begin
          report("unexpected", got, got);
        end else begin
          want = results_due.pop_front();
          if (got.id !== want.id) report("result_id", got, want);
          else if (got.status !== want.status) report("status", got, want);
          else if (got.expired !== want.expired) report("expired", got, want);
          else if (got.last !== want.last) report("last", got, want);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random timer requests into the timer table under
// varying stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          pending;
  int          errors;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  idle_cycles;
  logic [31:0] clock_ms;

  timer_table_expiry dut (.*);

  timer_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] kind, logic [5:0] id, logic p,
                              logic [31:0] dur, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, now, dur, p, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(50);
      2: return $urandom_range(50);
      default: return clock_ms + $urandom_range(40);
    endcase
  endfunction

  // mostly a well-formed timer life cycle, with noise
  task automatic random_request();
    logic [2:0] kind;
    int r;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(30);
    if (r < 15) kind = REQ_CREATE;
    else if (r < 40) kind = REQ_START;
    else if (r < 48) kind = REQ_STOP;
    else if (r < 58) kind = REQ_DELETE;
    else if (r < 80) kind = REQ_CHECK;
    else if (r < 95) kind = REQ_QUERY;
    else kind = 3'($urandom_range(7));
    send_request(kind, ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(11)),
                 1'($urandom), ($urandom_range(4) == 0) ? $urandom : $urandom_range(60),
                 ($urandom_range(3) == 0) ? pick_time() : clock_ms);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    clock_ms = 32'd100;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every request kind, open cases
    send_request(REQ_CHECK, 6'd0, 1'b0, 32'd0, 32'd5);            // nothing expired
    send_request(REQ_CREATE, 6'd0, 1'b1, 32'd10, 32'd0);          // id 0 periodic
    send_request(REQ_CREATE, 6'h3F, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, 6'd1, 1'b0, 32'd0, 32'd1);            // never started
    send_request(REQ_QUERY, 6'd1, 1'b0, 32'd0, 32'd0);
    send_request(REQ_START, 6'd0, 1'b0, 32'd0, 32'd100);
    send_request(REQ_START, 6'd1, 1'b0, 32'd0, 32'd5);            // sum wraps
    send_request(REQ_STOP, 6'd9, 1'b0, 32'd0, 32'd0);             // id not in use
    send_request(REQ_START, 6'h3F, 1'b0, 32'd0, 32'd0);
    send_request(REQ_CHECK, 6'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_CHECK, 6'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_STOP, 6'd0, 1'b0, 32'd0, 32'd0);
    send_request(REQ_STOP, 6'd0, 1'b0, 32'd0, 32'd0);             // stop of idle timer
    send_request(3'd6, 6'h2A, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 6'h15, 1'b0, 32'd0, 32'd0);
    send_request(REQ_DELETE, 6'd1, 1'b0, 32'd0, 32'd0);
    send_request(REQ_DELETE, 6'd1, 1'b0, 32'd0, 32'd0);
    for (int i = 0; i < 65; i++)
      send_request(REQ_CREATE, 6'($urandom), 1'(i), 32'(i % 3), 32'd0);
    for (int i = 0; i < 64; i++) send_request(REQ_START, 6'(i), 1'b0, 32'd0, 32'd50);
    send_request(REQ_CHECK, 6'd0, 1'b0, 32'd0, 32'd60);           // full table, ties
    send_request(REQ_CHECK, 6'd0, 1'b0, 32'd0, 32'd60);

    // pressure: long hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) random_request();
    join
    go_idle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 24) : 0;
      for (int i = 0; i < 18; i++) random_request();
      go_idle();
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/tte_pkg.sv
rtl/tte_front.sv
rtl/tte_back.sv
rtl/timer_table_expiry.sv
tb/sv/timer_table_checker.sv
tb/sv/testbench.sv
